>>> rtl/core/dhd_pkg.sv
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types, register indexes and the corner mapping function of the
// detection head decoder.
// ----------------------------------------------------------------------------
package dhd_pkg;

	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THRESHOLD = 3'd0,
		REG_OFFSET_X        = 3'd1,
		REG_OFFSET_Y        = 3'd2,
		REG_INVERSE_SCALE   = 3'd3,
		REG_IMAGE_WIDTH     = 3'd4,
		REG_IMAGE_HEIGHT    = 3'd5
	} reg_index_t;

	localparam logic [15:0] THRESHOLD_RST = 16'd16384;
	localparam logic [10:0] OFFSET_RST    = 11'd0;
	localparam logic [23:0] SCALE_RST     = 24'd65536;
	localparam logic [12:0] WIDTH_RST     = 13'd640;
	localparam logic [12:0] HEIGHT_RST    = 13'd480;

	typedef struct packed {
		logic [15:0] score_threshold;
		logic [10:0] offset_x;
		logic [10:0] offset_y;
		logic [23:0] inverse_scale;
		logic [12:0] image_width;
		logic [12:0] image_height;
	} cfg_t;

	// corners in Q.6, signed
	typedef struct packed {
		logic [13:0]        detection_index;
		logic [7:0]         best_class;
		logic [15:0]        best_score;
		logic signed [18:0] x1;
		logic signed [18:0] x2;
		logic signed [18:0] y1;
		logic signed [18:0] y2;
	} s1_t;

	// clamped corners in image pixels
	typedef struct packed {
		logic [13:0] detection_index;
		logic [7:0]  best_class;
		logic [15:0] best_score;
		logic [12:0] x1;
		logic [12:0] x2;
		logic [12:0] y1;
		logic [12:0] y2;
	} s2_t;

	function automatic logic [12:0] map_corner(input logic signed [18:0] q6,
			input logic [23:0] scale, input logic [12:0] limit);
		logic [41:0] prod;
		logic [19:0] v;
		prod = {24'd0, q6[17:0]} * {18'd0, scale};
		v    = prod[41:22];
		if (q6[18] || (q6 == 19'sd0))
			return 13'd0;
		else if (v > {7'd0, limit})
			return limit;
		else
			return v[12:0];
	endfunction

endpackage

>>> rtl/core/detection_head_decode_core.sv
// ----------------------------------------------------------------------------
// detection_head_decode_core
// Detector output head decode: best class per candidate, threshold, corner
// mapping to image pixels with clamping, drop of empty boxes.
// ----------------------------------------------------------------------------
// Stages: a candidate closed by its last score is registered in s1, then in s2 and
// then in s3, whose valid bit is out_valid; a stall can hold it in any of them.
// Throughput: one score per cycle while in_stall is low; only kept boxes occupy the
// stages, so the input stalls only once two further boxes wait behind a stalled result.
// Reset clears the running score, counters and all valid bits, and loads the
// registers with their defaults.
module detection_head_decode_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dhd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dhd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    center_x,
	input  logic [15:0]                    center_y,
	input  logic [15:0]                    box_w,
	input  logic [15:0]                    box_h,
	input  logic [15:0]                    cls_score,
	input  logic                           last_class,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [13:0]                    detection_index,
	output logic [7:0]                     best_class,
	output logic [15:0]                    best_score,
	output logic [12:0]                    left,
	output logic [12:0]                    top,
	output logic [12:0]                    span_x,
	output logic [12:0]                    span_y
);
	import dhd_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	logic valid_s2;
	logic ld_s2;
	logic ld_s3;
	s1_t  data_s1;
	s2_t  data_s2;

	dhd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dhd_score_track u_score_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.center_x    (center_x),
		.center_y    (center_y),
		.box_w       (box_w),
		.box_h       (box_h),
		.cls_score   (cls_score),
		.last_class  (last_class),
		.ld_s2       (ld_s2),
		.valid_s1    (valid_s1),
		.data_s1     (data_s1)
	);

	dhd_corner_map u_corner_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.ld_s2    (ld_s2),
		.ld_s3    (ld_s3),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	dhd_out_stage u_out_stage (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s2        (valid_s2),
		.data_s2         (data_s2),
		.ld_s3           (ld_s3),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.detection_index (detection_index),
		.best_class      (best_class),
		.best_score      (best_score),
		.left            (left),
		.top             (top),
		.span_x          (span_x),
		.span_y          (span_y)
	);

	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_x != 13'd0) && (span_y != 13'd0))
		else $error("result with empty box");

	a_box_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, left} + {1'b0, span_x}) <= {1'b0, cfg.image_width})
		else $error("result box past image width");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_valid && out_stall)
		else $error("input stalled with room in pipeline");

	a_score_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_score >= cfg.score_threshold)
		else $error("result below score threshold");

endmodule

>>> rtl/core/dhd_cfg_regs.sv
// ----------------------------------------------------------------------------
// dhd_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dhd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dhd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dhd_pkg::CFG_DATA_W-1:0]    cfg_data,
	output dhd_pkg::cfg_t                     cfg
);
	import dhd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= THRESHOLD_RST;
			cfg_q.offset_x        <= OFFSET_RST;
			cfg_q.offset_y        <= OFFSET_RST;
			cfg_q.inverse_scale   <= SCALE_RST;
			cfg_q.image_width     <= WIDTH_RST;
			cfg_q.image_height    <= HEIGHT_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SCORE_THRESHOLD: cfg_q.score_threshold <= cfg_data[15:0];
				REG_OFFSET_X:        cfg_q.offset_x        <= cfg_data[10:0];
				REG_OFFSET_Y:        cfg_q.offset_y        <= cfg_data[10:0];
				REG_INVERSE_SCALE:   cfg_q.inverse_scale   <= cfg_data[23:0];
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= cfg_data[12:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/dhd_score_track.sv
// ----------------------------------------------------------------------------
// dhd_score_track
// Running best score per candidate, candidate count, and the input stage
// that forms the Q.6 box corners of each closed candidate.
// ----------------------------------------------------------------------------
module dhd_score_track (
	input  logic          clk,
	input  logic          arst_n,
	input  dhd_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [15:0]   center_x,
	input  logic [15:0]   center_y,
	input  logic [15:0]   box_w,
	input  logic [15:0]   box_h,
	input  logic [15:0]   cls_score,
	input  logic          last_class,
	input  logic          ld_s2,
	output logic          valid_s1,
	output dhd_pkg::s1_t  data_s1
);
	import dhd_pkg::*;

	logic [15:0] run_max_q;
	logic [7:0]  run_class_q;
	logic [7:0]  class_cnt_q;
	logic [13:0] cand_cnt_q;
	logic [15:0] best_new;
	logic [7:0]  class_new;
	logic        ld_s1;
	logic        accept;
	logic        valid_q_s1;
	s1_t         data_q_s1;

	assign ld_s1    = !valid_q_s1 || ld_s2;
	assign in_stall = !ld_s1;
	assign accept   = in_valid && ld_s1;

	always_comb begin
		if (cls_score > run_max_q) begin
			best_new  = cls_score;
			class_new = class_cnt_q;
		end else begin
			best_new  = run_max_q;
			class_new = run_class_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q   <= '0;
			run_class_q <= '0;
			class_cnt_q <= '0;
			cand_cnt_q  <= '0;
		end else if (accept) begin
			if (last_class) begin
				run_max_q   <= '0;
				run_class_q <= '0;
				class_cnt_q <= '0;
				cand_cnt_q  <= cand_cnt_q + 14'd1;
			end else begin
				run_max_q   <= best_new;
				run_class_q <= class_new;
				class_cnt_q <= class_cnt_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q_s1 <= 1'b0;
		else if (ld_s1)
			valid_q_s1 <= accept && last_class && (best_new >= cfg.score_threshold);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q_s1.detection_index <= cand_cnt_q;
			data_q_s1.best_class      <= class_new;
			data_q_s1.best_score      <= best_new;
			data_q_s1.x1 <= $signed({2'b0, center_x, 1'b0}) - $signed({3'b0, box_w})
				- $signed({2'b0, cfg.offset_x, 6'b0});
			data_q_s1.x2 <= $signed({2'b0, center_x, 1'b0}) + $signed({3'b0, box_w})
				- $signed({2'b0, cfg.offset_x, 6'b0});
			data_q_s1.y1 <= $signed({2'b0, center_y, 1'b0}) - $signed({3'b0, box_h})
				- $signed({2'b0, cfg.offset_y, 6'b0});
			data_q_s1.y2 <= $signed({2'b0, center_y, 1'b0}) + $signed({3'b0, box_h})
				- $signed({2'b0, cfg.offset_y, 6'b0});
		end
	end

	assign valid_s1 = valid_q_s1;
	assign data_s1  = data_q_s1;

endmodule

>>> rtl/core/dhd_corner_map.sv
// ----------------------------------------------------------------------------
// dhd_corner_map
// Scale each corner to image pixels, floor and clamp to the image.
// ----------------------------------------------------------------------------
module dhd_corner_map (
	input  logic          clk,
	input  logic          arst_n,
	input  dhd_pkg::cfg_t cfg,
	input  logic          valid_s1,
	input  dhd_pkg::s1_t  data_s1,
	output logic          ld_s2,
	input  logic          ld_s3,
	output logic          valid_s2,
	output dhd_pkg::s2_t  data_s2
);
	import dhd_pkg::*;

	logic valid_q_s2;
	s2_t  data_q_s2;

	assign ld_s2 = !valid_q_s2 || ld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q_s2 <= 1'b0;
		else if (ld_s2)
			valid_q_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (ld_s2 && valid_s1) begin
			data_q_s2.detection_index <= data_s1.detection_index;
			data_q_s2.best_class      <= data_s1.best_class;
			data_q_s2.best_score      <= data_s1.best_score;
			data_q_s2.x1 <= map_corner(data_s1.x1, cfg.inverse_scale, cfg.image_width);
			data_q_s2.x2 <= map_corner(data_s1.x2, cfg.inverse_scale, cfg.image_width);
			data_q_s2.y1 <= map_corner(data_s1.y1, cfg.inverse_scale, cfg.image_height);
			data_q_s2.y2 <= map_corner(data_s1.y2, cfg.inverse_scale, cfg.image_height);
		end
	end

	assign valid_s2 = valid_q_s2;
	assign data_s2  = data_q_s2;

endmodule

>>> rtl/core/dhd_out_stage.sv
// ----------------------------------------------------------------------------
// dhd_out_stage
// Result register: box spans, drop of empty boxes, output handshake.
// ----------------------------------------------------------------------------
module dhd_out_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s2,
	input  dhd_pkg::s2_t data_s2,
	output logic         ld_s3,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [13:0]  detection_index,
	output logic [7:0]   best_class,
	output logic [15:0]  best_score,
	output logic [12:0]  left,
	output logic [12:0]  top,
	output logic [12:0]  span_x,
	output logic [12:0]  span_y
);
	import dhd_pkg::*;

	logic        valid_q_s3;
	logic        box_ok;
	logic [13:0] index_q_s3;
	logic [7:0]  class_q_s3;
	logic [15:0] score_q_s3;
	logic [12:0] left_q_s3;
	logic [12:0] top_q_s3;
	logic [12:0] span_x_q_s3;
	logic [12:0] span_y_q_s3;

	assign ld_s3  = !valid_q_s3 || !out_stall;
	assign box_ok = (data_s2.x2 > data_s2.x1) && (data_s2.y2 > data_s2.y1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q_s3 <= 1'b0;
		else if (ld_s3)
			valid_q_s3 <= valid_s2 && box_ok;
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && valid_s2) begin
			index_q_s3  <= data_s2.detection_index;
			class_q_s3  <= data_s2.best_class;
			score_q_s3  <= data_s2.best_score;
			left_q_s3   <= data_s2.x1;
			top_q_s3    <= data_s2.y1;
			span_x_q_s3 <= data_s2.x2 - data_s2.x1;
			span_y_q_s3 <= data_s2.y2 - data_s2.y1;
		end
	end

	assign out_valid       = valid_q_s3;
	assign detection_index = index_q_s3;
	assign best_class      = class_q_s3;
	assign best_score      = score_q_s3;
	assign left            = left_q_s3;
	assign top             = top_q_s3;
	assign span_x          = span_x_q_s3;
	assign span_y          = span_y_q_s3;

endmodule
